>>> hdl/hmsc_pkg.sv
// Package for the hours-minutes-seconds clock: word types, op and status
// codes, counter limits and the binary-to-BCD helper.
// No dependencies.
package hmsc_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned VALUE_W  = 7;
	localparam int unsigned SEC_W    = 6;
	localparam int unsigned MIN_W    = 6;
	localparam int unsigned HOUR_W   = 4;
	localparam int unsigned HOUR_BCD_W = 5;
	localparam int unsigned MS_BCD_W = 7;
	localparam int unsigned STATUS_W = 2;

	localparam logic [VALUE_W-1:0] MAX_SIXTY = 7'd59;
	localparam logic [VALUE_W-1:0] MAX_HOUR  = 7'd12;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_SET_SEC  = 3'd1,
		OP_SET_MIN  = 3'd2,
		OP_SET_HOUR = 3'd3,
		OP_READ     = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BAD_60 = 2'd1,
		ST_BAD_12 = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic [HOUR_BCD_W-1:0] hour_bcd;
		logic [MS_BCD_W-1:0]   minute_bcd;
		logic [MS_BCD_W-1:0]   second_bcd;
		logic [STATUS_W-1:0]   status;
	} rsp_word_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hours;
		logic [MIN_W-1:0]  minutes;
		logic [SEC_W-1:0]  seconds;
	} time_t;

	// Convert 0..63 to packed BCD; tens found by a short compare chain.
	function automatic logic [7:0] to_bcd(input logic [5:0] v);
		logic [3:0] tens;
		logic [5:0] rem;
		begin
			if (v >= 6'd60) begin
				tens = 4'd6;
			end else if (v >= 6'd50) begin
				tens = 4'd5;
			end else if (v >= 6'd40) begin
				tens = 4'd4;
			end else if (v >= 6'd30) begin
				tens = 4'd3;
			end else if (v >= 6'd20) begin
				tens = 4'd2;
			end else if (v >= 6'd10) begin
				tens = 4'd1;
			end else begin
				tens = 4'd0;
			end
			rem = v - 6'({2'b00, tens} * 6'd10);
			return {tens, rem[3:0]};
		end
	endfunction

endpackage

>>> hdl/hmsc_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on hmsc_pkg.
interface hmsc_req_if import hmsc_pkg::*; ();
	logic      valid;
	logic      ready;
	req_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hmsc_rsp_if import hmsc_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/hmsc_time_unit.sv
// Time counters with tick cascade and range-checked set operations.
// Depends on hmsc_pkg.
module hmsc_time_unit import hmsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [OP_W-1:0]    op,
	input  logic [VALUE_W-1:0] value,
	output time_t              time_nxt,
	output status_t            status_nxt
);

	time_t time_q;
	logic  sec_wrap;
	logic  min_wrap;

	assign sec_wrap = (time_q.seconds == SEC_W'(MAX_SIXTY));
	assign min_wrap = (time_q.minutes == MIN_W'(MAX_SIXTY));

	always_comb begin
		time_nxt   = time_q;
		status_nxt = ST_OK;
		case (op)
			OP_TICK: begin
				// advance seconds, carry into minutes and hours
				if (!sec_wrap) begin
					time_nxt.seconds = time_q.seconds + SEC_W'(1);
				end else begin
					time_nxt.seconds = '0;
					if (!min_wrap) begin
						time_nxt.minutes = time_q.minutes + MIN_W'(1);
					end else begin
						time_nxt.minutes = '0;
						if (time_q.hours == HOUR_W'(MAX_HOUR)) begin
							time_nxt.hours = '0;
						end else begin
							time_nxt.hours = time_q.hours + HOUR_W'(1);
						end
					end
				end
			end
			OP_SET_SEC: begin
				if (value <= MAX_SIXTY) begin
					time_nxt.seconds = value[SEC_W-1:0];
				end else begin
					status_nxt = ST_BAD_60;
				end
			end
			OP_SET_MIN: begin
				if (value <= MAX_SIXTY) begin
					time_nxt.minutes = value[MIN_W-1:0];
				end else begin
					status_nxt = ST_BAD_60;
				end
			end
			OP_SET_HOUR: begin
				if (value <= MAX_HOUR) begin
					time_nxt.hours = value[HOUR_W-1:0];
				end else begin
					status_nxt = ST_BAD_12;
				end
			end
			default: begin
				// read and unused codes: hold
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (en) begin
			time_q <= time_nxt;
		end
	end

endmodule

>>> hdl/hmsc_bcd_fmt.sv
// Formats binary time and status into the packed-BCD response word.
// Depends on hmsc_pkg.
module hmsc_bcd_fmt import hmsc_pkg::*; (
	input  time_t     time_bin,
	input  status_t   status,
	output rsp_word_t word
);

	logic [7:0] hour_full;
	logic [7:0] min_full;
	logic [7:0] sec_full;

	assign hour_full = to_bcd({2'b00, time_bin.hours});
	assign min_full  = to_bcd(time_bin.minutes);
	assign sec_full  = to_bcd(time_bin.seconds);

	assign word.hour_bcd   = hour_full[HOUR_BCD_W-1:0];
	assign word.minute_bcd = min_full[MS_BCD_W-1:0];
	assign word.second_bcd = sec_full[MS_BCD_W-1:0];
	assign word.status     = status;

endmodule

>>> hdl/hms_clock_with_set_and_bcd_read_core.sv
// Top level of the hours-minutes-seconds clock with set and BCD readout.
// Depends on hmsc_pkg, hmsc_if, hmsc_time_unit and hmsc_bcd_fmt.
//
//   channel | dir | word fields                                  | handshake
//   --------+-----+----------------------------------------------+-----------
//   req     | in  | op[2:0], value[6:0]                          | valid/ready
//   rsp     | out | hour_bcd[4:0], minute_bcd[6:0],              | valid/ready
//           |     | second_bcd[6:0], status[1:0]                 |
//
// One word in and one word out per cycle while rsp is not stalled; a word
// passes the input register, then the result register, before rsp valid
// rises for it.
// The time counters update in the same cycle the result register loads, so
// words apply strictly in order.
// Reset clears the counters to 00:00:00 and empties both registers.
// A stalled rsp holds its word; req stays ready while the input register is
// empty or its word can move into the result register.
module hms_clock_with_set_and_bcd_read_core import hmsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hmsc_req_if.sink   req,
	hmsc_rsp_if.source rsp
);

	// input register stage
	logic      valid_s1;
	req_word_t word_s1;

	// result register stage
	logic      valid_s2;
	rsp_word_t word_s2;

	logic      adv;
	time_t     time_nxt;
	status_t   status_nxt;
	rsp_word_t fmt_word;

	// advance the input stage whenever the result slot is free or draining
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			word_s1 <= req.data;
		end
	end

	// counters step only when the word commits to the result register
	hmsc_time_unit u_time (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.op         (word_s1.op),
		.value      (word_s1.value),
		.time_nxt   (time_nxt),
		.status_nxt (status_nxt)
	);

	hmsc_bcd_fmt u_fmt (
		.time_bin (time_nxt),
		.status   (status_nxt),
		.word     (fmt_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2 <= fmt_word;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = word_s2;

endmodule

>>> hdl/hmsc_checker.sv
// Port-level checks for the clock core, bound to the top level.
// Depends on hmsc_pkg and hms_clock_with_set_and_bcd_read_core.
module hmsc_checker import hmsc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp_data
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("rsp word changed while stalled");

	// seconds and minutes are valid BCD in 00..59
	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.second_bcd[6:4] <= 3'd5 && rsp_data.second_bcd[3:0] <= 4'd9
			&& rsp_data.minute_bcd[6:4] <= 3'd5 && rsp_data.minute_bcd[3:0] <= 4'd9)
		else $error("minute or second out of range");

	// hours are valid BCD in 00..12
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.hour_bcd[3:0] <= 4'd9
			&& (!rsp_data.hour_bcd[4] || rsp_data.hour_bcd[3:0] <= 4'd2))
		else $error("hour out of range");

	// status 3 never shows
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status == ST_OK || rsp_data.status == ST_BAD_60
			|| rsp_data.status == ST_BAD_12)
		else $error("undefined status code");

endmodule

bind hms_clock_with_set_and_bcd_read_core hmsc_checker u_hmsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
